/* design/settling_position_controller_core_assert.svh */
// Assertion macros for the settling position controller.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef SETTLING_POSITION_CONTROLLER_CORE_ASSERT_SVH
`define SETTLING_POSITION_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spc: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spc: next-cycle check failed");
`else
`define SPC_ASSERT_SAME(lbl, ante, cons)
`define SPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/spc_pkg.sv */
package spc_pkg;

  localparam int AngleW    = 20;
  localparam int ElapsedW  = 10;
  localparam int DriveW    = 8;
  localparam int CauseW    = 2;
  localparam int TargetW   = 13;
  localparam int TimeW     = 16;
  localparam int GainW     = 12;
  localparam int DrvMagW   = 7;
  localparam int WindowW   = 12;
  localparam int ErrW      = 21;
  localparam int AbsErrW   = 20;
  localparam int ProdW     = AbsErrW + GainW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  // Drive = gain * err / 25600 = ((gain * err) >> 8) / 100.
  localparam int GainFracShift = 8;
  localparam int ScaleDiv      = 100;
  localparam int QuotW         = 7;
  localparam int DivInW        = 14;
  localparam int ScaledW       = ProdW - GainFracShift;

  // The divide by 100 is a multiply by ceil(2^20 / 100) and a shift by 20.
  // It is exact for every dividend below 43690, which covers all dividends
  // whose quotient fits in QuotW bits.
  localparam int RecipShift = 20;
  localparam int RecipMul   = 10486;
  localparam int RecipW     = 14;
  localparam int RecipProdW = DivInW + RecipW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_DEG = 3'd0,
    REG_TIMEOUT_MS = 3'd1,
    REG_GAIN_Q8    = 3'd2,
    REG_MAX_DRIVE  = 3'd3,
    REG_MIN_DRIVE  = 3'd4,
    REG_WINDOW_CD  = 3'd5,
    REG_SETTLE_MS  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TargetW-1:0] target_deg;
    logic [TimeW-1:0]          timeout_ms;
    logic [GainW-1:0]          gain_q8;
    logic [DrvMagW-1:0]        max_drive;
    logic [DrvMagW-1:0]        min_drive;
    logic [WindowW-1:0]        window_cd;
    logic [TimeW-1:0]          settle_ms;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUNNING,
    ST_SETTLED,
    ST_TIMED_OUT
  } spc_state_t;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_SETTLED = 2'd1,
    CAUSE_TIMEOUT = 2'd2
  } cause_t;

  // Contents of the input register: one sample, already reduced to
  // error sign, scaled error magnitude and the window test.
  typedef struct packed {
    logic                start;
    logic [ElapsedW-1:0] elapsed;
    logic                neg;
    logic [ProdW-1:0]    mag;
    logic                in_win;
  } s1_t;

  // Outcome of one sample from the move sequencer.
  typedef struct packed {
    logic   active;
    logic   finished;
    cause_t cause;
  } fin_t;

endpackage

/* design/spc_ifs.sv */
interface spc_in_if;
  import spc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      start_req;
  logic signed [AngleW-1:0]  angle_cd;
  logic [ElapsedW-1:0]       elapsed_ms;
  modport source (output valid, start_req, angle_cd, elapsed_ms, input ready);
  modport sink   (input valid, start_req, angle_cd, elapsed_ms, output ready);
endinterface

interface spc_out_if;
  import spc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DriveW-1:0]  drive_speed;
  logic                      finished;
  logic [CauseW-1:0]         finish_cause;
  modport source (output valid, drive_speed, finished, finish_cause, input ready);
  modport sink   (input valid, drive_speed, finished, finish_cause, output ready);
endinterface

/* design/spc_stage_in.sv */
module spc_stage_in (
  input  logic                           clk,
  input  logic                           load,
  input  logic signed [spc_pkg::TargetW-1:0] target_deg,
  input  logic [spc_pkg::GainW-1:0]      gain_q8,
  input  logic [spc_pkg::WindowW-1:0]    window_cd,
  input  logic                           start_req,
  input  logic signed [spc_pkg::AngleW-1:0] angle_cd,
  input  logic [spc_pkg::ElapsedW-1:0]   elapsed_ms,
  output spc_pkg::s1_t                   s1_r
);
  import spc_pkg::*;

  logic signed [ErrW-1:0] tgt_ext;
  logic signed [ErrW-1:0] tgt_cd;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] err_abs;
  logic [AbsErrW-1:0]     aerr;
  s1_t                    s1_nxt;

  always_comb begin
    tgt_ext = ErrW'(target_deg);
    // Times 100 as 64 + 32 + 4.
    tgt_cd  = (tgt_ext <<< 6) + (tgt_ext <<< 5) + (tgt_ext <<< 2);
    err     = tgt_cd - ErrW'(angle_cd);
    err_abs = err[ErrW-1] ? -err : err;
    aerr    = err_abs[AbsErrW-1:0];

    s1_nxt.start   = start_req;
    s1_nxt.elapsed = elapsed_ms;
    s1_nxt.neg     = err[ErrW-1];
    s1_nxt.mag     = ProdW'(aerr) * ProdW'(gain_q8);
    s1_nxt.in_win  = aerr <= AbsErrW'(window_cd);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

/* design/spc_drive.sv */
module spc_drive (
  input  spc_pkg::s1_t                  s1,
  input  logic [spc_pkg::DrvMagW-1:0]   min_drive,
  input  logic [spc_pkg::DrvMagW-1:0]   max_drive,
  output logic signed [spc_pkg::DriveW-1:0] drive
);
  import spc_pkg::*;

  localparam logic [ScaledW-1:0] SatLimit = ScaledW'(ScaleDiv << QuotW);

  logic [ScaledW-1:0]    scaled;
  logic [DivInW-1:0]     dividend;
  logic [RecipProdW-1:0] prod;
  logic [QuotW-1:0]      quot;
  logic [DriveW-1:0]     mag;

  always_comb begin
    scaled   = s1.mag[ProdW-1:GainFracShift];
    dividend = scaled[DivInW-1:0];
    // Divide by 100 as a multiply by the rounded-up reciprocal and a shift.
    prod     = RecipProdW'(dividend) * RecipProdW'(RecipMul);
    quot     = prod[RecipShift+QuotW-1:RecipShift];
    // Quotients of 128 and more all clamp to max_drive anyway.
    if (scaled >= SatLimit) begin
      mag = DriveW'(1 << QuotW);
    end else begin
      mag = {1'b0, quot};
    end
    if (mag != '0 && mag < {1'b0, min_drive}) begin
      mag = {1'b0, min_drive};
    end
    if (mag > {1'b0, max_drive}) begin
      mag = {1'b0, max_drive};
    end
    drive = s1.neg ? -$signed(mag) : $signed(mag);
  end

endmodule

/* design/spc_fsm.sv */
module spc_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  spc_pkg::s1_t                s1,
  input  logic [spc_pkg::TimeW-1:0]   timeout_ms,
  input  logic [spc_pkg::TimeW-1:0]   settle_ms,
  output spc_pkg::fin_t               fin,
  output spc_pkg::spc_state_t         state
);
  import spc_pkg::*;

  spc_state_t       state_r, state_nxt;
  logic [TimeW-1:0] move_time_r, move_time_nxt;
  logic             in_win_r, in_win_nxt;
  logic [TimeW-1:0] win_time_r, win_time_nxt;
  logic             active;
  logic [TimeW-1:0] mt;
  logic [TimeW-1:0] wt;
  logic             settled;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [ElapsedW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + (TimeW+1)'(b);
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      move_time_r <= '0;
      in_win_r    <= 1'b0;
      win_time_r  <= '0;
    end else if (fire) begin
      state_r     <= state_nxt;
      move_time_r <= move_time_nxt;
      in_win_r    <= in_win_nxt;
      win_time_r  <= win_time_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    move_time_nxt = move_time_r;
    in_win_nxt    = in_win_r;
    win_time_nxt  = win_time_r;
    settled       = 1'b0;
    active        = s1.start || state_r == ST_RUNNING;
    mt            = s1.start ? '0 : sat_add(move_time_r, s1.elapsed);
    wt            = sat_add(win_time_r, s1.elapsed);

    if (active) begin
      move_time_nxt = mt;
      if (s1.in_win) begin
        // A start disarms the window timer, so its first sample only arms it.
        if (in_win_r && !s1.start) begin
          win_time_nxt = wt;
          settled      = wt >= settle_ms;
        end else begin
          in_win_nxt   = 1'b1;
          win_time_nxt = '0;
        end
      end else begin
        in_win_nxt   = 1'b0;
        win_time_nxt = '0;
      end
      if (settled) begin
        state_nxt = ST_SETTLED;
      end else if (mt >= timeout_ms) begin
        state_nxt = ST_TIMED_OUT;
      end else begin
        state_nxt = ST_RUNNING;
      end
    end

    fin.active = active;
    unique case (state_nxt)
      ST_SETTLED:   fin.cause = CAUSE_SETTLED;
      ST_TIMED_OUT: fin.cause = CAUSE_TIMEOUT;
      default:      fin.cause = CAUSE_NONE;
    endcase
    fin.finished = fin.cause != CAUSE_NONE;
  end

  assign state = state_r;

endmodule

/* design/settling_position_controller_core.sv */
// Settling position controller: takes one sensor sample per input beat and
// returns one result beat holding a signed proportional drive and the move
// status. The drive is gain_q8 (Q4.8, per degree) times the error in
// centidegrees, divided by 25600 and truncated toward zero; a nonzero drive
// below min_drive is raised to it, then the magnitude is clamped to
// max_drive. A start_req sample begins a move and clears both timers. The
// move finishes as settled once the error has stayed inside window_cd for
// settle_ms (the first in-window sample only arms that timer), or as timed
// out once the summed elapsed_ms reaches timeout_ms; settled wins if both
// happen on one sample. After finishing the drive is 0 (brake) until the
// next start. The block accepts one beat every clock cycle unless the
// result side stalls; the error and the gain multiply sit in front of
// the input register, the divide by 100, limits and move sequencer sit
// in front of the result register. The result register lets a new beat
// enter while a finished one still waits. Write configuration only
// while no beat is in flight.
`include "settling_position_controller_core_assert.svh"
module settling_position_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  spc_in_if.sink                          in_ch,
  spc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [spc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [spc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import spc_pkg::*;

  // Register values after reset.
  localparam logic signed [TargetW-1:0] TargetReset  = '0;
  localparam logic [TimeW-1:0]          TimeoutReset = TimeW'(1000);
  localparam logic [GainW-1:0]          GainReset    = GainW'(128);
  localparam logic [DrvMagW-1:0]        MaxReset     = DrvMagW'(127);
  localparam logic [DrvMagW-1:0]        MinReset     = DrvMagW'(8);
  localparam logic [WindowW-1:0]        WindowReset  = WindowW'(100);
  localparam logic [TimeW-1:0]          SettleReset  = TimeW'(100);

  cfg_t       cfg_r;
  s1_t        s1_r;
  fin_t       fin;
  spc_state_t fsm_state;

  logic                     s1_valid_r, s1_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DriveW-1:0] out_drive_r;
  logic                     out_fin_r;
  logic [CauseW-1:0]        out_cause_r;
  logic signed [DriveW-1:0] drive;
  logic                     adv;
  logic                     in_fire;
  logic                     s1_fire;
  logic                     fsm_done;

  // Configuration writes: one register per write, unknown indexes ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_deg <= TargetReset;
      cfg_r.timeout_ms <= TimeoutReset;
      cfg_r.gain_q8    <= GainReset;
      cfg_r.max_drive  <= MaxReset;
      cfg_r.min_drive  <= MinReset;
      cfg_r.window_cd  <= WindowReset;
      cfg_r.settle_ms  <= SettleReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_DEG: cfg_r.target_deg <= $signed(cfg_wdata[TargetW-1:0]);
        REG_TIMEOUT_MS: cfg_r.timeout_ms <= cfg_wdata[TimeW-1:0];
        REG_GAIN_Q8:    cfg_r.gain_q8    <= cfg_wdata[GainW-1:0];
        REG_MAX_DRIVE:  cfg_r.max_drive  <= cfg_wdata[DrvMagW-1:0];
        REG_MIN_DRIVE:  cfg_r.min_drive  <= cfg_wdata[DrvMagW-1:0];
        REG_WINDOW_CD:  cfg_r.window_cd  <= cfg_wdata[WindowW-1:0];
        REG_SETTLE_MS:  cfg_r.settle_ms  <= cfg_wdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Two-register pipeline. The sample register advances whenever the
  // result register is empty or being drained in the same cycle.
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_fire     = s1_valid_r && adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  spc_stage_in u_stage_in (
    .clk        (clk),
    .load       (in_fire),
    .target_deg (cfg_r.target_deg),
    .gain_q8    (cfg_r.gain_q8),
    .window_cd  (cfg_r.window_cd),
    .start_req  (in_ch.start_req),
    .angle_cd   (in_ch.angle_cd),
    .elapsed_ms (in_ch.elapsed_ms),
    .s1_r       (s1_r)
  );

  spc_drive u_drive (
    .s1        (s1_r),
    .min_drive (cfg_r.min_drive),
    .max_drive (cfg_r.max_drive),
    .drive     (drive)
  );

  spc_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .s1         (s1_r),
    .timeout_ms (cfg_r.timeout_ms),
    .settle_ms  (cfg_r.settle_ms),
    .fin        (fin),
    .state      (fsm_state)
  );

  // Result register. Outside a move the drive is forced to the brake.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_drive_r <= fin.active ? drive : '0;
      out_fin_r   <= fin.finished;
      out_cause_r <= fin.cause;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive_speed  = out_drive_r;
  assign out_ch.finished     = out_fin_r;
  assign out_ch.finish_cause = out_cause_r;

  // The sequencer has ended its move, by settling or by timeout.
  assign fsm_done = fsm_state == ST_SETTLED || fsm_state == ST_TIMED_OUT;

  // A sample that arrives after the move ended, with no start, brakes.
  `SPC_ASSERT_NEXT(a_brake_after_finish, s1_fire && !s1_r.start && fsm_done, out_drive_r == '0)
  // A held result with a full sample register must block a new beat.
  `SPC_ASSERT_SAME(a_stall_blocks_input, s1_valid_r && !adv, !in_ch.ready)
  // A start always leaves the sequencer out of the idle state.
  `SPC_ASSERT_NEXT(a_start_leaves_idle, s1_fire && s1_r.start, fsm_state != ST_IDLE)
  // The reported finished flag tracks the sequencer state it came from.
  `SPC_ASSERT_NEXT(a_finish_tracks_state, s1_fire, out_fin_r == fsm_done)

endmodule
